[rtl/kbwu_pkg.sv]
// Shared types and constants for the binary word unranking block.
// No dependencies; compile first.
package kbwu_pkg;

  localparam int CNT_W  = 7;
  localparam int RANK_W = 30;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Largest legal rank; table entries above it are pinned to RANK_MAX + 1.
  localparam rank_t RANK_MAX = 30'd1000000000;
  localparam rank_t SAT_VAL  = 30'd1000000001;

endpackage

[rtl/kbwu_ifs.sv]
// Valid/ready channel interfaces for the binary word unranking block.
// Depends on kbwu_pkg for payload types.
interface kbwu_in_if;
  logic            valid;
  logic            ready;
  kbwu_pkg::count_t count_first;
  kbwu_pkg::count_t count_second;
  kbwu_pkg::rank_t  rank;

  modport source (output valid, output count_first, output count_second, output rank,
                  input ready);
  modport sink   (input valid, input count_first, input count_second, input rank,
                  output ready);
endinterface

interface kbwu_out_if;
  logic valid;
  logic ready;
  logic symbol;
  logic error;
  logic last;

  modport source (output valid, output symbol, output error, output last, input ready);
  modport sink   (input valid, input symbol, input error, input last, output ready);
endinterface

[rtl/kbwu_table.sv]
// Saturating Pascal table in a one-write, two-read synchronous memory,
// filled by a sweep after reset. Depends on kbwu_pkg.
module kbwu_table #(
  parameter int MAX_LEN = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(MAX_LEN+1)-1:0] rd_row0_i,
  input  logic [$clog2(MAX_LEN+1)-1:0] rd_col0_i,
  input  logic [$clog2(MAX_LEN+1)-1:0] rd_row1_i,
  input  logic [$clog2(MAX_LEN+1)-1:0] rd_col1_i,
  output kbwu_pkg::rank_t            rd_data0_o,
  output kbwu_pkg::rank_t            rd_data1_o,
  output logic                       ready_o
);

  localparam int TDIM  = MAX_LEN + 1;
  localparam int DEPTH = TDIM * TDIM;
  localparam int CW    = $clog2(TDIM);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_LEN);

  function automatic logic [AW-1:0] tab_addr(logic [CW-1:0] row, logic [CW-1:0] col);
    return AW'(row) * AW'(TDIM) + AW'(col);
  endfunction

  kbwu_pkg::rank_t mem [DEPTH];
  kbwu_pkg::rank_t rd0_q, rd1_q;

  // fill sweep: stage 0 reads row n-1, stage 1 writes row n
  logic            filling_q;
  logic [CW-1:0]   fn_q, fk_q;
  logic            p_vld_q;
  logic [CW-1:0]   p_n_q, p_k_q;
  kbwu_pkg::rank_t prev_q, prev_d;

  logic [CW-1:0]   fill_row;
  logic [AW-1:0]   raddr0, raddr1, waddr;
  logic            re0;
  kbwu_pkg::rank_t cur, wdata;
  logic [kbwu_pkg::RANK_W:0] sum;

  assign fill_row = (fn_q == '0) ? '0 : fn_q - CW'(1);
  assign raddr0   = filling_q ? tab_addr(fill_row, fk_q) : tab_addr(rd_row0_i, rd_col0_i);
  assign raddr1   = tab_addr(rd_row1_i, rd_col1_i);
  assign re0      = filling_q || rd_en_i;
  assign waddr    = tab_addr(p_n_q, p_k_q);

  always_comb begin
    cur = (p_n_q == '0) ? '0 : rd0_q;
    sum = {1'b0, prev_q} + {1'b0, cur};
    if (p_k_q == '0) begin
      wdata  = (p_n_q == '0) ? kbwu_pkg::rank_t'(1) : kbwu_pkg::rank_t'(1);
      prev_d = (p_n_q == '0) ? '0 : kbwu_pkg::rank_t'(1);
    end else begin
      wdata  = (sum > {1'b0, kbwu_pkg::RANK_MAX}) ? kbwu_pkg::SAT_VAL
                                                   : sum[kbwu_pkg::RANK_W-1:0];
      prev_d = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) mem[waddr] <= wdata;
    if (re0) rd0_q <= mem[raddr0];
    if (rd_en_i) rd1_q <= mem[raddr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q <= 1'b1;
      fn_q      <= '0;
      fk_q      <= '0;
      p_vld_q   <= 1'b0;
    end else begin
      p_vld_q <= filling_q;
      if (filling_q) begin
        p_n_q <= fn_q;
        p_k_q <= fk_q;
        if (fk_q == LAST_IDX) begin
          fk_q <= '0;
          if (fn_q == LAST_IDX) filling_q <= 1'b0;
          else fn_q <= fn_q + CW'(1);
        end else begin
          fk_q <= fk_q + CW'(1);
        end
      end
      if (p_vld_q) prev_q <= prev_d;
    end
  end

  assign rd_data0_o = rd0_q;
  assign rd_data1_o = rd1_q;
  assign ready_o    = !filling_q && !p_vld_q;

endmodule

[rtl/kth_binary_word_unrank.sv]
// Lexicographic unranking of a two-symbol word of given symbol counts.
// Inputs: count_first zeros, count_second ones and a 1-based rank on in_i.
// Output: one beat per symbol on out_o, last set on the final beat; a
// single beat with error and last set when the counts are empty or sum above
// MAX_LEN, or the rank is zero, above 1e9 or above the number of words.
// Word counts come from a saturating Pascal table of (MAX_LEN+1)^2 entries
// held in one synchronous memory with two read ports.
// Reset: the table is built by a sweep over all (MAX_LEN+1)^2 entries;
// in_i.ready stays low until it is done.
// Sequence: accept, table lookup, range check, then one symbol per cycle
// while the receiver takes beats; an error item ends at the range check.
// Each symbol costs one memory read of both candidate entries for the next
// position and one 30-bit compare.
// One item is worked at a time; the next is accepted as soon as the last
// beat of the previous one sits in the output register.
// A stalled receiver holds the current beat and halts symbol generation.
// Depends on kbwu_pkg, kbwu_ifs and kbwu_table.
module kth_binary_word_unrank #(
  parameter int MAX_LEN = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  kbwu_in_if.sink    in_i,
  kbwu_out_if.source out_o
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int NW = kbwu_pkg::CNT_W + 1;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_LEN);

  typedef enum logic [2:0] {ST_FILL, ST_IDLE, ST_LOOK, ST_CHK, ST_RUN} state_e;

  state_e           state_q;
  kbwu_pkg::count_t a_q, z_q;
  kbwu_pkg::rank_t  r_q;
  logic             sel_q;
  logic             out_valid_q, sym_q, err_q, last_q;
  logic             out_valid_d, beat_load;

  logic             tbl_ready, rd_en;
  logic [CW-1:0]    row0, col0, row1, col1;
  kbwu_pkg::rank_t  rd0, rd1, cmp_val;

  logic [NW-1:0]    n_w;
  logic             len_ok, ofree, chk_err, run_sym, run_both, run_last;

  assign n_w      = {1'b0, a_q} + {1'b0, z_q};
  assign len_ok   = (n_w <= MAX_N);
  assign ofree    = !out_valid_q || out_o.ready;
  assign chk_err  = (n_w == '0) || !len_ok || (r_q == '0) ||
                    (r_q > kbwu_pkg::RANK_MAX) || (rd0 < r_q);
  assign cmp_val  = sel_q ? rd1 : rd0;
  assign run_both = (a_q != '0) && (z_q != '0);
  assign run_sym  = (a_q == '0) ? 1'b1 : ((z_q == '0) ? 1'b0 : (r_q > cmp_val));
  assign run_last = (n_w == NW'(1));
  assign rd_en    = (state_q == ST_LOOK) || ((state_q == ST_RUN) && ofree);

  // load a new beat on an error verdict or a symbol step, else hold or drain
  assign beat_load   = ofree && (((state_q == ST_CHK) && chk_err) || (state_q == ST_RUN));
  assign out_valid_d = beat_load || (out_valid_q && !out_o.ready);

  // LOOK fetches the word count and the first compare value; RUN fetches
  // both possible compare values of the next position.
  always_comb begin
    if (state_q == ST_LOOK) begin
      row0 = len_ok ? CW'(n_w) : '0;
      col0 = len_ok ? CW'(a_q) : '0;
      row1 = (len_ok && n_w != '0) ? CW'(n_w - NW'(1)) : '0;
      col1 = (len_ok && a_q != '0) ? CW'(a_q - kbwu_pkg::CNT_W'(1)) : '0;
    end else begin
      row0 = (len_ok && n_w >= NW'(2)) ? CW'(n_w - NW'(2)) : '0;
      col0 = (len_ok && a_q >= kbwu_pkg::CNT_W'(2)) ? CW'(a_q - kbwu_pkg::CNT_W'(2)) : '0;
      row1 = row0;
      col1 = (len_ok && a_q != '0) ? CW'(a_q - kbwu_pkg::CNT_W'(1)) : '0;
    end
  end

  kbwu_table #(
    .MAX_LEN (MAX_LEN)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_row0_i  (row0),
    .rd_col0_i  (col0),
    .rd_row1_i  (row1),
    .rd_col1_i  (col1),
    .rd_data0_o (rd0),
    .rd_data1_o (rd1),
    .ready_o    (tbl_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_FILL: begin
          if (tbl_ready) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            a_q     <= in_i.count_first;
            z_q     <= in_i.count_second;
            r_q     <= in_i.rank;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (!chk_err) begin
            sel_q   <= 1'b1;
            state_q <= ST_RUN;
          end else if (ofree) begin
            sym_q       <= 1'b0;
            err_q       <= 1'b1;
            last_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (ofree) begin
            sym_q       <= run_sym;
            err_q       <= 1'b0;
            last_q      <= run_last;
            sel_q       <= run_sym;
            if (run_sym) z_q <= z_q - kbwu_pkg::CNT_W'(1);
            else a_q <= a_q - kbwu_pkg::CNT_W'(1);
            // skip past all words that start with the first symbol here
            if (run_sym && run_both) r_q <= r_q - cmp_val;
            if (run_last) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = sym_q;
  assign out_o.error  = err_q;
  assign out_o.last   = last_q;

endmodule

[rtl/kbwu_checker.sv]
// Port-level assertions for kth_binary_word_unrank, bound to the top level.
// Sees only the channel signals; no package dependency.
module kbwu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_symbol_i,
  input logic out_error_i,
  input logic out_last_i
);

  // a stalled beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_symbol_i) && $stable(out_error_i) && $stable(out_last_i))
    else $error("output beat changed while stalled");

  // an error beat ends its item and carries no symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_last_i && !out_symbol_i)
    else $error("error beat without last or with symbol set");

  // a pending beat that is not last means the item is still in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input taken while an item is unfinished");

  // the lookup is a separate state: no new beat right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i && !$rose(out_valid_i))
    else $error("beat or accept too soon after an accept");

endmodule

bind kth_binary_word_unrank kbwu_checker u_kbwu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.symbol),
  .out_error_i  (out_o.error),
  .out_last_i   (out_o.last)
);
